// File: hw/rtl/percent_decoder_core_macros.svh
// assertion macros for the percent decoder core
`ifndef PERCENT_DECODER_CORE_MACROS_SVH
`define PERCENT_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define PD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("percent decoder check failed");

// next-cycle implication
`define PD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("percent decoder check failed");

`endif

// File: hw/rtl/pd_pkg.sv
// shared constants, types and helpers of the percent decoder
package pd_pkg;

  localparam logic [7:0] PCT_CHAR       = 8'h25;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;
  localparam logic [4:0] HEX_BAD        = 5'd16;
  localparam int         MAX_RESULTS    = 3;
  localparam int         PD_FIFO_DEPTH  = 4;

  // up to three result items produced by one input item, first in slot 0
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
    logic [2:0]      lasts;
  } pd_group_t;

  // 0..15 for a hex digit of either case, HEX_BAD otherwise
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
        v = ch - 8'h30;
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
        v = ch - 8'h61 + HEX_ALPHA_BASE;
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
        v = ch - 8'h41 + HEX_ALPHA_BASE;
      end else begin
        v = {3'b000, HEX_BAD};
      end
      return v[4:0];
    end
  endfunction

endpackage

// File: hw/rtl/pd_stream_if.sv
// stream interfaces for raw and decoded bytes
interface pd_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pd_decoded_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hw/rtl/pd_decode.sv
// escape tracker: hold state and result group for each accepted byte
module pd_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output pd_pkg::pd_group_t group
);
  import pd_pkg::*;

  localparam logic [1:0] HOLD_NONE  = 2'd0;
  localparam logic [1:0] HOLD_PCT   = 2'd1;
  localparam logic [1:0] HOLD_DIGIT = 2'd2;

  logic [1:0] held_count, held_count_next;
  logic [7:0] held_digit, held_digit_next;
  logic [4:0] hi, lo;
  logic       plain_last;
  logic       plain_hold;

  always_comb begin
    hi              = hex_value(held_digit);
    lo              = hex_value(in_byte);
    held_count_next = held_count;
    held_digit_next = held_digit;
    group           = '0;
    // after a bad second character the byte is re-examined as not last
    plain_last      = (held_count == HOLD_PCT) ? 1'b0 : in_last;
    plain_hold      = (in_byte == PCT_CHAR) && !plain_last;

    case (held_count)
      HOLD_PCT: begin
        if (in_last) begin
          group.n         = 2'd2;
          group.bytes[0]  = PCT_CHAR;
          group.bytes[1]  = in_byte;
          group.lasts[1]  = 1'b1;
          held_count_next = HOLD_NONE;
        end else if (!lo[4]) begin
          held_digit_next = in_byte;
          held_count_next = HOLD_DIGIT;
        end else begin
          group.bytes[0] = PCT_CHAR;
          if (plain_hold) begin
            group.n         = 2'd1;
            held_count_next = HOLD_PCT;
          end else begin
            group.n         = 2'd2;
            group.bytes[1]  = in_byte;
            held_count_next = HOLD_NONE;
          end
        end
      end
      HOLD_DIGIT: begin
        if (!hi[4] && !lo[4] && {hi[3:0], lo[3:0]} != 8'd0) begin
          group.n         = 2'd1;
          group.bytes[0]  = {hi[3:0], lo[3:0]};
          group.lasts[0]  = in_last;
          held_count_next = HOLD_NONE;
        end else begin
          // failed escape: percent and held digit pass, third byte re-examined
          group.bytes[0] = PCT_CHAR;
          group.bytes[1] = held_digit;
          if (plain_hold) begin
            group.n         = 2'd2;
            held_count_next = HOLD_PCT;
          end else begin
            group.n         = 2'd3;
            group.bytes[2]  = in_byte;
            group.lasts[2]  = in_last;
            held_count_next = HOLD_NONE;
          end
        end
      end
      default: begin
        if (plain_hold) begin
          held_count_next = HOLD_PCT;
        end else begin
          group.n         = 2'd1;
          group.bytes[0]  = in_byte;
          group.lasts[0]  = in_last;
          held_count_next = HOLD_NONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HOLD_NONE;
      held_digit <= 8'd0;
    end else if (advance) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

// File: hw/rtl/pd_fifo.sv
// shifting result queue: takes a group of up to three items, gives one a cycle when popped
module pd_fifo #(
  parameter int DEPTH = pd_pkg::PD_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  pd_pkg::pd_group_t          group,
  input  logic                       pop,
  output logic [7:0]                 head_byte,
  output logic                       head_last,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import pd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    q_byte [DEPTH];
  logic          q_last [DEPTH];
  logic [7:0]    q_byte_next [DEPTH];
  logic          q_last_next [DEPTH];
  logic [CW-1:0] base;
  logic [CW-1:0] count_next;

  always_comb begin
    // write position of the first new item once the head has left
    base = count - CW'(pop);
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && i < DEPTH - 1) begin
        q_byte_next[i] = q_byte[(i + 1) % DEPTH];
        q_last_next[i] = q_last[(i + 1) % DEPTH];
      end else begin
        q_byte_next[i] = q_byte[i];
        q_last_next[i] = q_last[i];
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (push && k < int'(group.n) && (base + CW'(k)) == CW'(i)) begin
          q_byte_next[i] = group.bytes[k];
          q_last_next[i] = group.lasts[k];
        end
      end
    end
    count_next = count + CW'(push ? group.n : 2'd0) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_byte[i] <= q_byte_next[i];
      q_last[i] <= q_last_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign head_byte = q_byte[0];
  assign head_last = q_last[0];

endmodule

// File: hw/rtl/percent_decoder_core.sv
// top level of the streaming url percent decoder
// raw (sink): one encoded byte per item with in_last marking the end of a string.
// decoded (source): one byte per item; out_last rides on the final result of a
// string. a '%' and two hex digits of either case become one byte; escapes with
// a bad digit, a zero value or too few bytes before the end pass through as is,
// and the byte that breaks one is looked at again, so a '%' can start an escape.
// results of each taken item enter the registered queue and leave it in order.
// throughput: one raw item per cycle while each gives at most one result and
// decoded is ready; an item gives zero to three results, and decoded moves one a
// cycle, so a failed escape briefly holds raw back. raw.ready is high while the
// result queue of DEPTH entries has room for a full group of three.
// a stall on decoded fills the queue; items wait there in order, none is lost.
// reset (rst, synchronous) empties the queue and drops any held escape.
`include "percent_decoder_core_macros.svh"

module percent_decoder_core #(
  parameter int DEPTH = pd_pkg::PD_FIFO_DEPTH
) (
  input logic          clk,
  input logic          rst,
  pd_raw_if.sink       raw,
  pd_decoded_if.source decoded
);
  import pd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  pd_group_t     group;
  logic          in_fire;
  logic          pop;
  logic [CW-1:0] count;

  assign raw.ready = count <= CW'(DEPTH - MAX_RESULTS);
  assign in_fire   = raw.valid && raw.ready;

  pd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (in_fire),
    .in_byte (raw.in_byte),
    .in_last (raw.in_last),
    .group   (group)
  );

  pd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .group     (group),
    .pop       (pop),
    .head_byte (decoded.out_byte),
    .head_last (decoded.out_last),
    .count     (count)
  );

  assign decoded.valid = count != '0;
  assign pop           = decoded.valid && decoded.ready;

  `PD_ASSERT_NOW(a_count_in_range, 1'b1, count <= CW'(DEPTH))
  `PD_ASSERT_NOW(a_group_fits, in_fire, (count + CW'(group.n)) <= CW'(DEPTH))
  `PD_ASSERT_NEXT(a_empty_stays_empty, !in_fire && count == '0, !decoded.valid)

endmodule

// File: tb/sv/percent_decoder_core_tb.sv
// testbench for the streaming url percent decoder core
`timescale 1ns / 1ps

module percent_decoder_core_tb;
  import pd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 50;
  localparam int RANDOM_ITEM_GOAL = 170;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_item_t;

  logic clk;
  logic rst;

  pd_raw_if     raw_ch ();
  pd_decoded_if dec_ch ();

  percent_decoder_core DUT (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_ch),
    .decoded (dec_ch)
  );

  dec_item_t  expected_bytes[$];
  esc_state_t esc_state = ESC_NONE;
  logic [7:0] esc_digit = 8'h00;
  int         err_count = 0;
  int         raw_sent = 0;
  bit         no_idle = 1'b0;
  bit         hold_off_req = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b0, ch[3:0]};
    if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      return {1'b0, ch[3:0] + 4'd9};
    end
    return HEX_BAD;
  endfunction

  function automatic void queue_result(input logic [7:0] b, input logic l);
    dec_item_t r;
    r.data = b;
    r.last = l;
    expected_bytes.push_back(r);
  endfunction

  // byte looked at with nothing held: a non-final '%' opens an escape
  function automatic void take_plain(input logic [7:0] b, input logic l);
    if (b == PCT_CHAR && !l) begin
      esc_state = ESC_PCT;
    end else begin
      esc_state = ESC_NONE;
      queue_result(b, l);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic l);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] val;
    case (esc_state)
      ESC_PCT: begin
        if (l) begin
          queue_result(PCT_CHAR, 1'b0);
          queue_result(b, 1'b1);
          esc_state = ESC_NONE;
        end else if (hex_nibble(b) != HEX_BAD) begin
          esc_digit = b;
          esc_state = ESC_DIGIT;
        end else begin
          queue_result(PCT_CHAR, 1'b0);
          take_plain(b, 1'b0);
        end
      end
      ESC_DIGIT: begin
        hi = hex_nibble(esc_digit);
        lo = hex_nibble(b);
        val = {hi[3:0], lo[3:0]};
        if (hi != HEX_BAD && lo != HEX_BAD && val != 8'h00) begin
          queue_result(val, l);
          esc_state = ESC_NONE;
        end else begin
          queue_result(PCT_CHAR, 1'b0);
          queue_result(esc_digit, 1'b0);
          take_plain(b, l);
        end
      end
      // the unused code behaves as nothing held
      default: take_plain(b, l);
    endcase
  endfunction

  // valid stays high between back-to-back items, lowered only for a gap
  task automatic send_raw(input logic [7:0] b, input logic l);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      raw_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    raw_ch.valid   <= 1'b1;
    raw_ch.in_byte <= b;
    raw_ch.in_last <= l;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    decode_byte(b, l);
    raw_sent++;
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    foreach (text[i]) send_raw(text[i], i == text.size() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    if ($urandom_range(0, 1) == 1) return 8'h61 + 8'(nib) - 8'd10;
    return 8'h41 + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) != HEX_BAD);
    return b;
  endfunction

  // decoded sink: random stalls, plus one long hold-off on request
  initial begin : decoded_sink
    int stall_left;
    stall_left = 0;
    dec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        dec_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
        dec_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        dec_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        dec_ch.ready <= 1'b0;
      end else begin
        dec_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_decoded
    dec_item_t want;
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte %02h last %0b",
                                  dec_ch.out_byte, dec_ch.out_last));
      end else begin
        want = expected_bytes.pop_front();
        if (dec_ch.out_byte !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    dec_ch.out_byte, want.data));
        end
        if (dec_ch.out_last !== want.last) begin
          report_mismatch($sformatf("out_last %0b, expected %0b (byte %02h)",
                                    dec_ch.out_last, want.last, want.data));
        end
      end
    end
  end

  task automatic test_plain_extremes();
    send_raw(8'h00, 1'b0);
    send_raw(8'hFF, 1'b1);
  endtask

  task automatic test_valid_escapes();
    send_text('{PCT_CHAR, "4", "1"});
    send_text('{PCT_CHAR, "F", "f"});
  endtask

  task automatic test_zero_value();
    send_text('{PCT_CHAR, "0", "0"});
  endtask

  // a bad second character passes through and a following '%' opens a fresh escape
  task automatic test_bad_second();
    send_text('{PCT_CHAR, "G", PCT_CHAR, "4", "1"});
  endtask

  task automatic test_bad_third();
    send_text('{PCT_CHAR, "4", PCT_CHAR, "2", "a"});
  endtask

  task automatic test_end_too_near();
    send_text('{PCT_CHAR});
    send_text('{PCT_CHAR, "4"});
  endtask

  task automatic send_random_string();
    logic [7:0] text[$];
    logic [7:0] v;
    int         segs;
    int         r;
    segs = $urandom_range(1, 6);
    repeat (segs) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else if (r < 75) begin
        v = 8'($urandom_range(1, 255));
        text.push_back(PCT_CHAR);
        text.push_back(hex_char(v[7:4]));
        text.push_back(hex_char(v[3:0]));
      end else if (r < 85) begin
        text.push_back(PCT_CHAR);
        text.push_back("0");
        text.push_back("0");
      end else begin
        text.push_back(PCT_CHAR);
        case ($urandom_range(0, 3))
          0: text.push_back(non_hex_char());
          1: begin
            text.push_back(hex_char(4'($urandom_range(0, 15))));
            text.push_back(non_hex_char());
          end
          2: ;
          default: text.push_back(hex_char(4'($urandom_range(0, 15))));
        endcase
      end
    end
    send_text(text);
  endtask

  task automatic test_random_strings();
    no_idle = 1'b1;
    repeat (3) send_random_string();
    no_idle = 1'b0;
    while (raw_sent < RANDOM_ITEM_GOAL) send_random_string();
  endtask

  // failed escapes of up to three items each are sent while decoded is held off
  task automatic test_backpressure();
    logic [7:0] text[$];
    repeat (6) begin
      text.push_back(PCT_CHAR);
      text.push_back(hex_char(4'($urandom_range(0, 15))));
      text.push_back(non_hex_char());
    end
    no_idle = 1'b1;
    hold_off_req = 1'b1;
    send_text(text);
    no_idle = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    raw_ch.valid   <= 1'b0;
    raw_ch.in_byte <= 8'h00;
    raw_ch.in_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_plain_extremes();
    test_valid_escapes();
    test_zero_value();
    test_bad_second();
    test_bad_third();
    test_end_too_near();
    test_backpressure();
    test_random_strings();
    raw_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
